/* src/scpu_pkg.sv */
// Shared types, constants and helpers of the 16-bit CPU core.
package scpu_pkg;

  // Word memory size in words; a power of two from 256 to 65536.
  localparam int MEM_WORDS = 4096;
  localparam int MEM_AW    = $clog2(MEM_WORDS);

  localparam int XLEN   = 16;
  localparam int NREG   = 16;
  localparam int RIDX_W = 4;
  localparam int CMD_W  = 3;
  localparam int ADDR_W = 12;
  localparam int CFG_IDX_W = 1;

  localparam logic [RIDX_W-1:0] SP_IDX = 4'd13;
  localparam logic [RIDX_W-1:0] LR_IDX = 4'd14;
  localparam logic [RIDX_W-1:0] PC_IDX = 4'd15;

  localparam logic [XLEN-1:0] START_RST = 16'd256;
  localparam logic [XLEN-1:0] STACK_RST = 16'd4031;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STACK = 1'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_STEP     = 3'd0,
    CMD_MEM_WR   = 3'd1,
    CMD_MEM_RD   = 3'd2,
    CMD_REG_RD   = 3'd3,
    CMD_SOFT_RST = 3'd4
  } cmd_e;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_AND   = 4'd2,
    OP_OR    = 4'd3,
    OP_NOT   = 4'd4,
    OP_SHL   = 4'd5,
    OP_SHR   = 4'd6,
    OP_SAR   = 4'd7,
    OP_LOAD  = 4'd8,
    OP_ST    = 4'd9,
    OP_JMP   = 4'd10,
    OP_BEQ   = 4'd11,
    OP_BNE   = 4'd12,
    OP_BLT   = 4'd13,
    OP_CALL  = 4'd14,
    OP_RET   = 4'd15
  } op_e;

  typedef enum logic [1:0] {
    MODE_GPR = 2'd0,
    MODE_LIT = 2'd1,
    MODE_DIR = 2'd2,
    MODE_IND = 2'd3
  } mode_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // latch the accepted transaction
    logic fetch;     // read instruction word at PC
    logic decode;    // capture instruction, advance PC
    logic oper;      // read source register, issue operand read
    logic exec;      // execute the instruction
    logic pop;       // RET: take link word from stack
    logic mem_wr;    // write command
    logic mem_rd;    // read command, issue
    logic mem_wait;  // read command, capture
    logic reg_rd;    // register read command
    logic soft_rst;  // soft reset command
    logic capture;   // load the output register
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic halted;
    op_e  op;
  } sts_t;

  // Word address wrapped to the memory size
  function automatic logic [MEM_AW-1:0] mem_addr(input logic [XLEN-1:0] a);
    return a[MEM_AW-1:0];
  endfunction

endpackage

/* src/scpu_ram.sv */
// Generic single-port RAM with registered read.
module scpu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write, or read into the output register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/scpu_ctrl.sv */
// Sequencing state machine of the 16-bit CPU core.
module scpu_ctrl import scpu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CMD_W-1:0] cmd_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  sts_t             sts_i,
  output ctl_t             ctl_o
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_DECODE   = 11'b000_0000_0010,
    S_OPER     = 11'b000_0000_0100,
    S_EXEC     = 11'b000_0000_1000,
    S_POP      = 11'b000_0001_0000,
    S_MEM_WR   = 11'b000_0010_0000,
    S_MEM_RD   = 11'b000_0100_0000,
    S_MEM_WAIT = 11'b000_1000_0000,
    S_REG_RD   = 11'b001_0000_0000,
    S_SOFT_RST = 11'b010_0000_0000,
    S_DONE     = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          ctl_o.load = 1'b1;
          case (cmd_e'(cmd_i))
            CMD_STEP: begin
              if (sts_i.halted) begin
                state_d = S_DONE;
              end else begin
                ctl_o.fetch = 1'b1;
                state_d     = S_DECODE;
              end
            end
            CMD_MEM_WR:   state_d = S_MEM_WR;
            CMD_MEM_RD:   state_d = S_MEM_RD;
            CMD_REG_RD:   state_d = S_REG_RD;
            CMD_SOFT_RST: state_d = S_SOFT_RST;
            default:      state_d = S_DONE;
          endcase
        end
      end
      S_DECODE: begin
        ctl_o.decode = 1'b1;
        state_d      = S_OPER;
      end
      S_OPER: begin
        ctl_o.oper = 1'b1;
        state_d    = S_EXEC;
      end
      S_EXEC: begin
        ctl_o.exec = 1'b1;
        state_d    = (sts_i.op == OP_RET) ? S_POP : S_DONE;
      end
      S_POP: begin
        ctl_o.pop = 1'b1;
        state_d   = S_DONE;
      end
      S_MEM_WR: begin
        ctl_o.mem_wr = 1'b1;
        state_d      = S_DONE;
      end
      S_MEM_RD: begin
        ctl_o.mem_rd = 1'b1;
        state_d      = S_MEM_WAIT;
      end
      S_MEM_WAIT: begin
        ctl_o.mem_wait = 1'b1;
        state_d        = S_DONE;
      end
      S_REG_RD: begin
        ctl_o.reg_rd = 1'b1;
        state_d      = S_DONE;
      end
      S_SOFT_RST: begin
        ctl_o.soft_rst = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        // output register free or being emptied this cycle
        if (!out_valid_q || out_ready_i) begin
          ctl_o.capture = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output transaction valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_o.capture) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_step_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i == CMD_STEP && !sts_i.halted) |=> state_q == S_DECODE)
    else $error("step not followed by decode");

  a_ret_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && sts_i.op == OP_RET) |=> state_q == S_POP)
    else $error("RET without stack pop");

  a_done_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !out_valid_q) |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished transaction not presented");

endmodule

/* src/scpu_dp.sv */
// Datapath of the 16-bit CPU core: registers, flags, ALU and word memory.
module scpu_dp import scpu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctl_t                 ctl_i,
  output sts_t                 sts_o,
  input  logic [ADDR_W-1:0]    addr_i,
  input  logic [XLEN-1:0]      data_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [XLEN-1:0]      cfg_data_i,
  output logic [XLEN-1:0]      read_data_o,
  output logic [XLEN-1:0]      pc_o,
  output logic                 halted_o,
  output logic                 zero_flag_o,
  output logic                 carry_flag_o,
  output logic                 sign_flag_o,
  output logic                 overflow_flag_o
);

  // Architectural state
  logic [XLEN-1:0] rf_q [NREG];
  logic [XLEN-1:0] rf_d [NREG];
  logic            z_q, c_q, s_q, o_q;
  logic            z_d, c_d, s_d, o_d;
  logic            halted_q, halted_d;
  logic [XLEN-1:0] start_q, stack_q;

  // Transaction and instruction holding registers
  logic [ADDR_W-1:0] addr_q;
  logic [XLEN-1:0]   data_q;
  logic [XLEN-1:0]   ins_q;
  logic [XLEN-1:0]   prev_q;
  logic [XLEN-1:0]   srcv_q;
  logic [XLEN-1:0]   rd_q;

  // Output register
  logic [XLEN-1:0] out_rd_q, out_pc_q;
  logic            out_halted_q, out_z_q, out_c_q, out_s_q, out_o_q;

  // Instruction fields
  op_e              ins_op;
  mode_e            ins_mode;
  logic [RIDX_W-1:0] ins_dst;
  logic [5:0]       ins_src;
  logic [XLEN-1:0]  src_imm;

  assign ins_op   = op_e'(ins_q[15:12]);
  assign ins_dst  = ins_q[11:8];
  assign ins_mode = mode_e'(ins_q[7:6]);
  assign ins_src  = ins_q[5:0];
  assign src_imm  = {{(XLEN-6){1'b0}}, ins_src};

  assign sts_o.halted = halted_q;
  assign sts_o.op     = ins_op;

  // Register file read port
  logic [RIDX_W-1:0] rf_raddr;
  logic [XLEN-1:0]   rf_rdata;

  always_comb begin
    if (ctl_i.oper) begin
      rf_raddr = ins_src[RIDX_W-1:0];
    end else if (ctl_i.reg_rd) begin
      rf_raddr = addr_q[RIDX_W-1:0];
    end else begin
      rf_raddr = ins_dst;
    end
  end

  assign rf_rdata = rf_q[rf_raddr];

  // Word memory
  logic              ram_en, ram_we;
  logic [MEM_AW-1:0] ram_addr;
  logic [XLEN-1:0]   ram_wdata, ram_rdata;

  scpu_ram #(
    .WIDTH (XLEN),
    .DEPTH (MEM_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Source operand and destination value
  logic [XLEN-1:0] sv, dv;

  always_comb begin
    case (ins_mode)
      MODE_GPR: sv = srcv_q;
      MODE_LIT: sv = src_imm;
      default:  sv = ram_rdata;
    endcase
  end

  assign dv = rf_rdata;

  // Memory port selection
  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = mem_addr(rf_q[PC_IDX]);
    ram_wdata = dv;
    if (ctl_i.fetch) begin
      ram_en = 1'b1;
    end else if (ctl_i.oper) begin
      ram_en   = 1'b1;
      ram_addr = (ins_mode == MODE_DIR) ? mem_addr(src_imm) : mem_addr(rf_rdata);
    end else if (ctl_i.exec) begin
      case (ins_op)
        OP_ST: begin
          ram_en   = 1'b1;
          ram_we   = 1'b1;
          ram_addr = (ins_mode == MODE_GPR || ins_mode == MODE_IND) ?
                     mem_addr(srcv_q) : mem_addr(src_imm);
        end
        OP_CALL: begin
          ram_en    = 1'b1;
          ram_we    = 1'b1;
          ram_addr  = mem_addr(rf_q[SP_IDX] - 16'd1);
          ram_wdata = rf_q[LR_IDX];
        end
        OP_RET: begin
          ram_en   = 1'b1;
          ram_addr = mem_addr(rf_q[SP_IDX]);
        end
        default: ram_en = 1'b0;
      endcase
    end else if (ctl_i.mem_wr) begin
      ram_en    = 1'b1;
      ram_we    = 1'b1;
      ram_addr  = mem_addr({{(XLEN-ADDR_W){1'b0}}, addr_q});
      ram_wdata = data_q;
    end else if (ctl_i.mem_rd) begin
      ram_en   = 1'b1;
      ram_addr = mem_addr({{(XLEN-ADDR_W){1'b0}}, addr_q});
    end
  end

  // ALU
  logic [XLEN:0]   sum;
  logic [XLEN-1:0] res;
  logic            res_c, res_o, big_shift;
  logic [3:0]      shamt;

  assign sum       = {1'b0, dv} + {1'b0, sv};
  assign shamt     = sv[3:0];
  assign big_shift = |sv[XLEN-1:4];

  always_comb begin
    res_c = 1'b0;
    res_o = 1'b0;
    case (ins_op)
      OP_ADD: begin
        res   = sum[XLEN-1:0];
        res_c = sum[XLEN];
        res_o = ~(dv[15] ^ sv[15]) & (dv[15] ^ res[15]);
      end
      OP_SUB: begin
        res   = dv - sv;
        res_c = (dv < sv);
        res_o = (dv[15] ^ sv[15]) & (dv[15] ^ res[15]);
      end
      OP_AND:  res = dv & sv;
      OP_OR:   res = dv | sv;
      OP_NOT:  res = ~dv;
      OP_SHL:  res = big_shift ? '0 : (dv << shamt);
      OP_SHR:  res = big_shift ? '0 : (dv >> shamt);
      OP_SAR:  res = big_shift ? {XLEN{dv[15]}} : XLEN'($signed(dv) >>> shamt);
      default: res = sv;
    endcase
  end

  // Next register file, flags and halted
  always_comb begin
    rf_d     = rf_q;
    z_d      = z_q;
    c_d      = c_q;
    s_d      = s_q;
    o_d      = o_q;
    halted_d = halted_q;
    if (ctl_i.soft_rst) begin
      for (int i = 0; i < NREG; i++) begin
        rf_d[i] = '0;
      end
      rf_d[SP_IDX] = stack_q;
      rf_d[PC_IDX] = start_q;
      z_d = 1'b0;
      c_d = 1'b0;
      s_d = 1'b0;
      o_d = 1'b0;
      halted_d = 1'b0;
    end else if (ctl_i.decode) begin
      rf_d[PC_IDX] = rf_q[PC_IDX] + 16'd1;
    end else if (ctl_i.exec) begin
      if (ins_op inside {[OP_ADD:OP_LOAD]}) begin
        rf_d[ins_dst] = res;
        z_d = (res == '0);
        s_d = res[15];
        c_d = res_c;
        o_d = res_o;
      end
      case (ins_op)
        OP_JMP: rf_d[PC_IDX] = sv;
        OP_BEQ: if (z_q) rf_d[PC_IDX] = sv;
        OP_BNE: if (!z_q) rf_d[PC_IDX] = sv;
        OP_BLT: if (s_q != o_q) rf_d[PC_IDX] = sv;
        OP_CALL: begin
          rf_d[SP_IDX] = rf_q[SP_IDX] - 16'd1;
          rf_d[LR_IDX] = rf_q[PC_IDX];
          rf_d[PC_IDX] = sv;
        end
        OP_RET: rf_d[PC_IDX] = rf_q[LR_IDX];
        default: ;
      endcase
      // a step that leaves PC where it was halts the core
      if (rf_d[PC_IDX] == prev_q) begin
        halted_d = 1'b1;
      end
    end else if (ctl_i.pop) begin
      rf_d[LR_IDX] = ram_rdata;
      rf_d[SP_IDX] = rf_q[SP_IDX] + 16'd1;
    end
  end

  // Architectural state and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NREG; i++) begin
        rf_q[i] <= '0;
      end
      rf_q[SP_IDX] <= STACK_RST;
      rf_q[PC_IDX] <= START_RST;
      z_q      <= 1'b0;
      c_q      <= 1'b0;
      s_q      <= 1'b0;
      o_q      <= 1'b0;
      halted_q <= 1'b0;
      start_q  <= START_RST;
      stack_q  <= STACK_RST;
    end else begin
      rf_q     <= rf_d;
      z_q      <= z_d;
      c_q      <= c_d;
      s_q      <= s_d;
      o_q      <= o_d;
      halted_q <= halted_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_START: start_q <= cfg_data_i;
          CFG_STACK: stack_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Transaction, instruction and read data holding registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      addr_q <= addr_i;
      data_q <= data_i;
      rd_q   <= '0;
    end
    if (ctl_i.decode) begin
      ins_q  <= ram_rdata;
      prev_q <= rf_q[PC_IDX];
    end
    if (ctl_i.oper) begin
      srcv_q <= rf_rdata;
    end
    if (ctl_i.mem_wait) begin
      rd_q <= ram_rdata;
    end
    if (ctl_i.reg_rd) begin
      rd_q <= rf_rdata;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      out_rd_q     <= rd_q;
      out_pc_q     <= rf_q[PC_IDX];
      out_halted_q <= halted_q;
      out_z_q      <= z_q;
      out_c_q      <= c_q;
      out_s_q      <= s_q;
      out_o_q      <= o_q;
    end
  end

  assign read_data_o     = out_rd_q;
  assign pc_o            = out_pc_q;
  assign halted_o        = out_halted_q;
  assign zero_flag_o     = out_z_q;
  assign carry_flag_o    = out_c_q;
  assign sign_flag_o     = out_s_q;
  assign overflow_flag_o = out_o_q;

  a_halt_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(halted_q) |-> $past(ctl_i.exec))
    else $error("halted set outside instruction execution");

  a_call_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.exec && ins_op == OP_CALL) |=>
      (rf_q[SP_IDX] == $past(rf_q[SP_IDX]) - 16'd1))
    else $error("CALL did not decrement the stack pointer");

  a_soft_reset_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.soft_rst |=> (rf_q[PC_IDX] == $past(start_q) && !halted_q))
    else $error("soft reset did not restore PC and halted");

endmodule

/* src/sixteen_bit_cpu_core_step.sv */
// Top level of the command-driven 16-bit CPU core.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one command transaction:
//   cmd_i, addr_i, data_i. Output channel (out_valid_o/out_ready_i) returns
//   one result transaction per command: read_data_o, pc_o, halted_o and
//   the four condition flags as they stand after the command.
//   Config channel (cfg_valid_i/cfg_ready_o) writes start_address (index 0)
//   or stack_start (index 1); it is always ready and is meant for idle time.
// Sequence (accept to out_valid_o): a step fetches, decodes, reads its operand
//   and executes, and RET then pops the link word; a memory read issues, then
//   captures; a step while halted or an unknown command only returns a result.
// Commands do not overlap: the next one is accepted the cycle after the result
//   is loaded into the output register.
// The single-port word memory serves instruction fetch, operand read and
//   store or stack access one at a time, each in its own state.
// Reset: registers clear, SP and PC load their reset values, flags and
//   halted clear; memory contents are undefined until written.
// Output stall: a finished result waits in the output register; the next
//   command is accepted and runs, then holds until that register is freed.
module sixteen_bit_cpu_core_step import scpu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [CMD_W-1:0]     cmd_i,
  input  logic [ADDR_W-1:0]    addr_i,
  input  logic [XLEN-1:0]      data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [XLEN-1:0]      read_data_o,
  output logic [XLEN-1:0]      pc_o,
  output logic                 halted_o,
  output logic                 zero_flag_o,
  output logic                 carry_flag_o,
  output logic                 sign_flag_o,
  output logic                 overflow_flag_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [XLEN-1:0]      cfg_data_i
);

  ctl_t ctl;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  scpu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  scpu_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .addr_i          (addr_i),
    .data_i          (data_i),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .read_data_o     (read_data_o),
    .pc_o            (pc_o),
    .halted_o        (halted_o),
    .zero_flag_o     (zero_flag_o),
    .carry_flag_o    (carry_flag_o),
    .sign_flag_o     (sign_flag_o),
    .overflow_flag_o (overflow_flag_o)
  );

endmodule
